FILE: src/spmf_pkg.sv
// ----------------------------------------------------------------------------
// Strict priority multi FIFO package
// Sizes, status and mode codes, and the structs passed between the node
// store, the level table and the sequencer.
// ----------------------------------------------------------------------------
package spmf_pkg;

	localparam int NUM_LEVELS = 32;
	localparam int NODE_COUNT = 256;
	localparam int TAG_BITS   = 16;

	localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int CNT_W  = $clog2(NODE_COUNT + 1);

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam logic [1:0] ST_PUSHED  = 2'd0;
	localparam logic [1:0] ST_DROPPED = 2'd1;
	localparam logic [1:0] ST_POPPED  = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	typedef struct packed {
		logic                pay_en;
		logic [NODE_W-1:0]   pay_addr;
		logic [TAG_BITS-1:0] pay_data;
		logic                link_en;
		logic [NODE_W-1:0]   link_addr;
		logic [NODE_W-1:0]   link_data;
	} mem_wr_t;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [LVL_W-1:0]  lvl;
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] next;
	} lvl_upd_t;

	function automatic logic [NODE_W-1:0] next_node(input logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] r;
		if (n == NODE_W'(NODE_COUNT - 1)) begin
			r = '0;
		end else begin
			r = n + 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: src/spmf_node_mem.sv
// ----------------------------------------------------------------------------
// Shared node store
// Payload and link memories with one registered read port and one write port
// each. Link entries never written read as the initial free chain.
// ----------------------------------------------------------------------------
module spmf_node_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [spmf_pkg::NODE_W-1:0]   rd_addr,
	input  spmf_pkg::mem_wr_t             wr,
	output logic [spmf_pkg::NODE_W-1:0]   rd_link,
	output logic [spmf_pkg::TAG_BITS-1:0] rd_payload
);
	import spmf_pkg::*;

	logic [TAG_BITS-1:0] pay_mem  [NODE_COUNT];
	logic [NODE_W-1:0]   link_mem [NODE_COUNT];
	logic [NODE_COUNT-1:0] link_vld_q;
	logic [NODE_W-1:0]   link_rd_q;
	logic [NODE_W-1:0]   addr_rd_q;
	logic                vld_rd_q;
	logic [TAG_BITS-1:0] pay_rd_q;

	always_ff @(posedge clk) begin
		if (wr.pay_en) begin
			pay_mem[wr.pay_addr] <= wr.pay_data;
		end
		if (rd_en) begin
			pay_rd_q <= pay_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.link_en) begin
			link_mem[wr.link_addr] <= wr.link_data;
		end
		if (rd_en) begin
			link_rd_q <= link_mem[rd_addr];
			addr_rd_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
			vld_rd_q   <= 1'b0;
		end else begin
			if (wr.link_en) begin
				link_vld_q[wr.link_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= link_vld_q[rd_addr];
			end
		end
	end

	assign rd_link    = vld_rd_q ? link_rd_q : next_node(addr_rd_q);
	assign rd_payload = pay_rd_q;

endmodule

FILE: src/spmf_level_tbl.sv
// ----------------------------------------------------------------------------
// Level table
// Head, tail and occupancy of each priority level, plus the most urgent
// occupied level.
// ----------------------------------------------------------------------------
module spmf_level_tbl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spmf_pkg::lvl_upd_t          upd,
	input  logic [spmf_pkg::LVL_W-1:0]  sel_lvl,
	output logic                        sel_ne,
	output logic [spmf_pkg::NODE_W-1:0] sel_tail,
	output logic                        any_ne,
	output logic [spmf_pkg::LVL_W-1:0]  pop_lvl,
	output logic [spmf_pkg::NODE_W-1:0] pop_head
);
	import spmf_pkg::*;

	logic [NODE_W-1:0]     head_q [NUM_LEVELS];
	logic [NODE_W-1:0]     tail_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] ne_q;

	always_comb begin
		pop_lvl = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (ne_q[i]) begin
				pop_lvl = LVL_W'(i);
			end
		end
	end

	assign any_ne   = |ne_q;
	assign pop_head = head_q[pop_lvl];
	assign sel_ne   = ne_q[sel_lvl];
	assign sel_tail = tail_q[sel_lvl];

	always_ff @(posedge clk) begin
		if (upd.push) begin
			tail_q[upd.lvl] <= upd.node;
			if (!ne_q[upd.lvl]) begin
				head_q[upd.lvl] <= upd.node;
			end
		end else if (upd.pop && (tail_q[upd.lvl] != upd.node)) begin
			head_q[upd.lvl] <= upd.next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
		end else if (upd.push) begin
			ne_q[upd.lvl] <= 1'b1;
		end else if (upd.pop && (tail_q[upd.lvl] == upd.node)) begin
			ne_q[upd.lvl] <= 1'b0;
		end
	end

endmodule

FILE: src/strict_priority_multi_fifo_core.sv
// ----------------------------------------------------------------------------
// Strict priority multi FIFO core
// Per-level job FIFOs chained as linked lists in one shared node store.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   in       | in_valid/in_ready  | mode, priority_req, job_tag
//   out      | out_valid/out_ready| status, out_tag, out_priority
//
// A push, a pop, a dropped push and an empty pop all run the same way:
// the accept cycle reads the node store, the final cycle writes it (for a push
// or a pop) and loads the result register, which drives out_valid.
// Reset needs no clearing pass; unwritten links read as the initial free chain.
// A stalled output holds the final cycle until the result register is free;
// in_ready is low while an item is in work.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [4:0]  priority_req,
	input  logic [15:0] job_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] out_tag,
	output logic [4:0]  out_priority
);
	import spmf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PUSH = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_NOP  = 2'd3;

	logic [1:0]          state_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [NODE_W-1:0]   node_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [1:0]          st_q;
	logic [NODE_W-1:0]   free_head_q;
	logic [CNT_W-1:0]    free_cnt_q;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [15:0]         out_tag_q;
	logic [4:0]          out_prio_q;

	logic                accept;
	logic                fin;
	logic [LVL_W-1:0]    lvl_sat;
	logic [NODE_W-1:0]   rd_addr;
	logic [NODE_W-1:0]   rd_link;
	logic [TAG_BITS-1:0] rd_payload;
	logic                sel_ne;
	logic [NODE_W-1:0]   sel_tail;
	logic                any_ne;
	logic [LVL_W-1:0]    pop_lvl;
	logic [NODE_W-1:0]   pop_head;
	mem_wr_t             wr;
	lvl_upd_t            upd;
	logic [TAG_BITS+15:0] tag_in_ext;
	logic [TAG_BITS+15:0] tag_out_ext;
	logic [LVL_W+4:0]     lvl_out_ext;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign fin      = (state_q != S_IDLE) && (!out_valid_q || out_ready);
	assign lvl_sat  = (int'(priority_req) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
	                                                     : LVL_W'(priority_req);
	assign rd_addr  = (mode == MODE_POP) ? pop_head : free_head_q;

	assign tag_in_ext  = (TAG_BITS + 16)'(job_tag);
	assign tag_out_ext = (TAG_BITS + 16)'(rd_payload);
	assign lvl_out_ext = (LVL_W + 5)'(lvl_q);

	spmf_node_mem u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_addr    (rd_addr),
		.wr         (wr),
		.rd_link    (rd_link),
		.rd_payload (rd_payload)
	);

	spmf_level_tbl u_lvl (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.sel_lvl  (lvl_q),
		.sel_ne   (sel_ne),
		.sel_tail (sel_tail),
		.any_ne   (any_ne),
		.pop_lvl  (pop_lvl),
		.pop_head (pop_head)
	);

	always_comb begin
		wr  = '0;
		upd = '0;
		if (fin) begin
			unique case (state_q)
				S_PUSH: begin
					wr.pay_en    = 1'b1;
					wr.pay_addr  = free_head_q;
					wr.pay_data  = tag_q;
					wr.link_en   = sel_ne;
					wr.link_addr = sel_tail;
					wr.link_data = free_head_q;
					upd.push     = 1'b1;
					upd.lvl      = lvl_q;
					upd.node     = free_head_q;
				end
				S_POP: begin
					wr.link_en   = 1'b1;
					wr.link_addr = node_q;
					wr.link_data = free_head_q;
					upd.pop      = 1'b1;
					upd.lvl      = lvl_q;
					upd.node     = node_q;
					upd.next     = rd_link;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lvl_q  <= (mode == MODE_POP) ? pop_lvl : lvl_sat;
			node_q <= pop_head;
			tag_q  <= tag_in_ext[TAG_BITS-1:0];
			st_q   <= (mode == MODE_POP) ? ST_EMPTY : ST_DROPPED;
		end
		if (fin) begin
			unique case (state_q)
				S_PUSH: begin
					status_q   <= ST_PUSHED;
					out_tag_q  <= '0;
					out_prio_q <= '0;
				end
				S_POP: begin
					status_q   <= ST_POPPED;
					out_tag_q  <= tag_out_ext[15:0];
					out_prio_q <= lvl_out_ext[4:0];
				end
				default: begin
					status_q   <= st_q;
					out_tag_q  <= '0;
					out_prio_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= '0;
			free_cnt_q  <= CNT_W'(NODE_COUNT);
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (mode == MODE_POP) begin
					state_q <= any_ne ? S_POP : S_NOP;
				end else begin
					state_q <= (free_cnt_q == '0) ? S_NOP : S_PUSH;
				end
			end else if (fin) begin
				state_q <= S_IDLE;
				if (state_q == S_PUSH) begin
					free_head_q <= rd_link;
					free_cnt_q  <= free_cnt_q - 1'b1;
				end else if (state_q == S_POP) begin
					free_head_q <= node_q;
					free_cnt_q  <= free_cnt_q + 1'b1;
				end
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_tag      = out_tag_q;
	assign out_priority = out_prio_q;

`ifndef SYNTHESIS
	a_empty_iff_all_free: assert property (@(posedge clk) disable iff (!arst_n)
		any_ne == (free_cnt_q != CNT_W'(NODE_COUNT)))
		else $error("level occupancy disagrees with free count");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= CNT_W'(NODE_COUNT))
		else $error("free count above node count");

	a_push_has_node: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && state_q == S_PUSH) |-> (free_cnt_q != '0))
		else $error("push committed with no free node");

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && state_q == S_POP) |-> (any_ne && free_cnt_q != CNT_W'(NODE_COUNT)))
		else $error("pop committed with nothing queued");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (out_valid && state_q == S_IDLE))
		else $error("finished item produced no result");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Strict priority multi FIFO core testbench
// Sends push and pop items through the input channel in random bursts, keeps
// its own node store, free list and per-level lists to predict each result,
// and checks every result against the oldest prediction. Phases fill the
// store past full, drain it past empty, and mix both, with receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

	import spmf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;

	typedef struct {
		logic        m;
		logic [4:0]  p;
		logic [15:0] t;
		bit          drain_first;
	} job_req_t;

	typedef struct {
		logic [1:0]  st;
		logic [15:0] tag;
		logic [4:0]  prio;
	} job_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [4:0]  priority_req;
	logic [15:0] job_tag;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [15:0] out_tag;
	logic [4:0]  out_priority;

	job_req_t    job_requests[$];
	job_result_t expected_results[$];

	logic [TAG_BITS-1:0] node_tag[NODE_COUNT];
	logic [NODE_W-1:0]   node_next[NODE_COUNT];
	logic [NODE_W-1:0]   lvl_first[NUM_LEVELS];
	logic [NODE_W-1:0]   lvl_last[NUM_LEVELS];
	logic [NUM_LEVELS-1:0] lvl_busy;
	logic [NODE_W-1:0]   free_first;
	logic [CNT_W-1:0]    free_nodes;

	int errors;
	int items_sent;
	int results_seen;
	int n_stored;
	int n_dropped;
	int n_popped;
	int n_empty;
	int burst_left;
	int gap_left;
	int hold_left;
	bit hold_done;
	int rx_cycle;
	int idle_cycles;

	strict_priority_multi_fifo_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.priority_req (priority_req),
		.job_tag      (job_tag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_tag      (out_tag),
		.out_priority (out_priority)
	);

	always #10 clk = ~clk;

	function automatic logic [NODE_W-1:0] next_node_tb(input int i);
		return (i + 1 < NODE_COUNT) ? NODE_W'(i + 1) : '0;
	endfunction

	task automatic schedule_job(input logic m, input logic [4:0] p, input logic [15:0] t);
		job_result_t r;
		int lvl;
		logic [NODE_W-1:0] n;
		bit found;
		r.st = ST_EMPTY;
		r.tag = '0;
		r.prio = '0;
		found = 0;
		if (m == MODE_PUSH) begin
			lvl = int'(p);
			if (lvl >= NUM_LEVELS) begin
				lvl = NUM_LEVELS - 1;
			end
			if (free_nodes == 0) begin
				r.st = ST_DROPPED;
				n_dropped++;
			end else begin
				n = free_first;
				free_first = node_next[n];
				free_nodes = free_nodes - 1'b1;
				node_tag[n] = TAG_BITS'(t);
				node_next[n] = '0;
				if (lvl_busy[lvl]) begin
					node_next[lvl_last[lvl]] = n;
				end else begin
					lvl_first[lvl] = n;
				end
				lvl_last[lvl] = n;
				lvl_busy[lvl] = 1'b1;
				r.st = ST_PUSHED;
				n_stored++;
			end
		end else begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				if (!found && lvl_busy[i]) begin
					found = 1;
					n = lvl_first[i];
					r.tag = 16'(node_tag[n]);
					r.prio = 5'(i);
					r.st = ST_POPPED;
					if (n == lvl_last[i]) begin
						lvl_busy[i] = 1'b0;
					end else begin
						lvl_first[i] = node_next[n];
					end
					node_next[n] = free_first;
					free_first = n;
					free_nodes = free_nodes + 1'b1;
				end
			end
			if (found) begin
				n_popped++;
			end else begin
				n_empty++;
			end
		end
		expected_results.push_back(r);
	endtask

	function automatic void add_request(input logic m, input logic [4:0] p,
			input logic [15:0] t, input bit drain);
		job_req_t q;
		q.m = m;
		q.p = p;
		q.t = t;
		q.drain_first = drain;
		job_requests.push_back(q);
	endfunction

	function automatic void add_random_phase(input int count, input int pop_pct);
		logic [4:0] p;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				p = 5'($urandom_range(0, 3));
			end else begin
				p = 5'($urandom_range(0, 31));
			end
			add_request(($urandom_range(1, 100) <= pop_pct) ? MODE_POP : MODE_PUSH,
				p, 16'($urandom), i == 0);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		job_req_t req;
		bit busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_PUSH;
			priority_req <= '0;
			job_tag <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				schedule_job(mode, priority_req, job_tag);
				items_sent++;
				busy = 0;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (job_requests.size() != 0 &&
						!(job_requests[0].drain_first && expected_results.size() != 0)) begin
					req = job_requests.pop_front();
					in_valid <= 1'b1;
					mode <= req.m;
					priority_req <= req.p;
					job_tag <= req.t;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		job_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cycle <= 0;
			hold_left <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d, out_tag %h, out_priority %0d",
						status, out_tag, out_priority);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.st) begin
						$error("status mismatch: expected %0d, actual %0d", want.st, status);
						errors++;
					end
					if (out_tag !== want.tag) begin
						$error("out_tag mismatch: expected %h, actual %h", want.tag, out_tag);
						errors++;
					end
					if (out_priority !== want.prio) begin
						$error("out_priority mismatch: expected %0d, actual %0d",
							want.prio, out_priority);
						errors++;
					end
				end
			end
			if (results_seen == 100 && !hold_done) begin
				hold_done = 1;
				hold_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				case (rx_cycle[7:6])
					2'd0: out_ready <= 1'b1;
					2'd1: out_ready <= 1'($urandom_range(0, 1));
					2'd2: out_ready <= (rx_cycle % 3) != 0;
					default: out_ready <= $urandom_range(0, 3) != 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_PUSH;
		priority_req = '0;
		job_tag = '0;
		out_ready = 1'b0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		n_stored = 0;
		n_dropped = 0;
		n_popped = 0;
		n_empty = 0;
		hold_done = 0;
		idle_cycles = 0;
		for (int i = 0; i < NODE_COUNT; i++) begin
			node_tag[i] = '0;
			node_next[i] = next_node_tb(i);
		end
		for (int i = 0; i < NUM_LEVELS; i++) begin
			lvl_first[i] = '0;
			lvl_last[i] = '0;
		end
		lvl_busy = '0;
		free_first = '0;
		free_nodes = CNT_W'(NODE_COUNT);

		// pop on empty, extremes of level and tag, FIFO order within a level
		add_request(MODE_POP, 5'd31, 16'hFFFF, 0);
		add_request(MODE_PUSH, 5'd0, 16'h0000, 0);
		add_request(MODE_PUSH, 5'd31, 16'hFFFF, 0);
		add_request(MODE_PUSH, 5'd31, 16'h1234, 0);
		add_request(MODE_PUSH, 5'd0, 16'h5555, 0);
		add_request(MODE_PUSH, 5'd16, 16'hAAAA, 0);
		repeat (5) add_request(MODE_POP, 5'($urandom), 16'($urandom), 0);
		add_request(MODE_POP, 5'd0, 16'h0000, 0);
		add_request(MODE_PUSH, 5'd1, 16'h0001, 0);
		add_request(MODE_PUSH, 5'd8, 16'h8000, 0);
		add_request(MODE_PUSH, 5'd2, 16'h7FFF, 0);
		add_request(MODE_PUSH, 5'd4, 16'h00FF, 0);
		add_request(MODE_POP, 5'd0, 16'h0000, 0);
		add_request(MODE_PUSH, 5'd0, 16'hFF00, 0);
		repeat (4) add_request(MODE_POP, 5'($urandom), 16'($urandom), 0);
		add_request(MODE_POP, 5'd31, 16'hFFFF, 0);

		add_random_phase(20, 50);
		add_random_phase(262, 0);
		add_random_phase(262, 100);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (job_requests.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (10) @(posedge clk);

		$display("Sent %0d items: %0d pushes stored, %0d dropped on full store,", items_sent,
			n_stored, n_dropped);
		$display("%0d pops returned a job, %0d pops found every level empty.", n_popped, n_empty);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: strict_priority_multi_fifo_core.f
src/spmf_pkg.sv
src/spmf_node_mem.sv
src/spmf_level_tbl.sv
src/strict_priority_multi_fifo_core.sv
test/testbench.sv
